FILE: hdl/mpp_pkg.sv
// Shared types and constants of the memory paging port unit.
// No dependencies; imported by every module of the block.
package mpp_pkg;

    // Number of RAM pages; a power of two from 16 to 256.
    localparam int PAGE_COUNT = 256;
    localparam logic [7:0] PAGE_MASK = 8'(PAGE_COUNT - 1);

    localparam int TUSER_IN_W = 5;
    localparam int TDATA_IN_W = 16;
    localparam int TDATA_OUT_W = 56;

    typedef enum logic [1:0] {
        ACT_REG_WR = 2'd0,
        ACT_REG_RD = 2'd1,
        ACT_7FFD   = 2'd2,
        ACT_FETCH  = 2'd3
    } t_action;

    // Register select codes
    localparam logic [2:0] REG_MEMCONF = 3'd0;
    localparam logic [2:0] REG_PAGE0   = 3'd1;
    localparam logic [2:0] REG_PAGE1   = 3'd2;
    localparam logic [2:0] REG_PAGE2   = 3'd3;
    localparam logic [2:0] REG_PAGE3   = 3'd4;
    localparam logic [2:0] REG_VPAGE   = 3'd5;
    localparam logic [2:0] REG_STATUS  = 3'd6;
    localparam logic [2:0] REG_DMA     = 3'd7;

    // 7FFD extension modes, memconf bits 7:6
    localparam logic [1:0] EXT_512K  = 2'd0;
    localparam logic [1:0] EXT_128K  = 2'd1;
    localparam logic [1:0] EXT_AUTO  = 2'd2;
    localparam logic [1:0] EXT_1024K = 2'd3;

    // memconf bit positions
    localparam int MC_ROM128   = 0;
    localparam int MC_UNMAPPED = 2;
    localparam int MC_W0_RAM   = 3;

    // 7FFD latch bit positions
    localparam int LT_VIDEO = 3;
    localparam int LT_ROM   = 4;
    localparam int LT_LOCK  = 5;

    localparam logic [7:0] RD_POWER_UP  = 8'h40;
    localparam logic [7:0] RD_NONE      = 8'h00;
    localparam logic [7:0] RD_OPEN      = 8'hFF;
    localparam logic [7:0] PC_DOS_ENTRY = 8'h3D;
    localparam logic [7:0] PC_DOS_EXIT  = 8'h40;
    localparam logic [7:0] ROM_PAGE_MSK = 8'h1F;
    localparam logic [7:0] LOCK_CLR_MSK = 8'hDF;
    localparam logic [7:0] VPAGE_NORMAL = 8'd5;
    localparam logic [7:0] VPAGE_SHADOW = 8'd7;

    typedef struct packed {
        t_action    action;
        logic [2:0] sel;
        logic [7:0] data;
        logic [7:0] pc_high;
    } t_item;

    typedef struct packed {
        logic [3:0][7:0] pages;
        logic [7:0]      memcfg;
        logic [7:0]      latch;
        logic [7:0]      vpage;
        logic            power_up;
        logic            dos;
    } t_state;

    typedef struct packed {
        logic [7:0] read_data;
        logic [7:0] w0_page;
        logic       w0_rom;
        logic [7:0] w1_page;
        logic [7:0] w2_page;
        logic [7:0] w3_page;
        logic [7:0] video_page;
        logic       dos_active;
    } t_result;

endpackage

FILE: hdl/mpp_state.sv
// Paging state registers and their update for one bus item.
// Depends on mpp_pkg.
module mpp_state (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  mpp_pkg::t_item i_item,
    output mpp_pkg::t_state o_next,
    output logic [7:0]     o_read_data
);
    import mpp_pkg::*;

    t_state     r_st;
    t_state     n_st;
    logic [7:0] n_rd;
    logic [7:0] v_latch;
    logic [1:0] wr_idx;

    assign wr_idx = 2'(i_item.sel - REG_PAGE0);

    always_comb begin
        n_st    = r_st;
        n_rd    = RD_NONE;
        v_latch = i_item.data;
        unique case (i_item.action)
            ACT_REG_WR: begin
                unique case (i_item.sel) inside
                    REG_MEMCONF: begin
                        n_st.memcfg        = i_item.data;
                        n_st.latch[LT_ROM] = i_item.data[MC_ROM128];
                    end
                    REG_PAGE0, REG_PAGE1, REG_PAGE2, REG_PAGE3: begin
                        n_st.pages[wr_idx] = i_item.data;
                    end
                    REG_VPAGE: n_st.vpage = i_item.data;
                    default: ;
                endcase
            end
            ACT_REG_RD: begin
                unique case (i_item.sel) inside
                    REG_STATUS: begin
                        n_rd          = r_st.power_up ? RD_POWER_UP : RD_NONE;
                        n_st.power_up = 1'b0;
                    end
                    REG_PAGE2: n_rd = r_st.pages[2];
                    REG_PAGE3: n_rd = r_st.pages[3];
                    REG_DMA:   n_rd = RD_NONE;
                    default:   n_rd = RD_OPEN;
                endcase
            end
            ACT_7FFD: begin
                if (!r_st.latch[LT_LOCK]) begin
                    case (r_st.memcfg[7:6]) inside
                        EXT_128K: n_st.pages[3] = {5'd0, i_item.data[2:0]};
                        EXT_1024K: begin
                            n_st.pages[3] = {2'd0, i_item.data[5], i_item.data[7:6],
                                             i_item.data[2:0]};
                            // this mode never locks
                            v_latch = i_item.data & LOCK_CLR_MSK;
                        end
                        EXT_512K, EXT_AUTO: begin
                            n_st.pages[3] = {3'd0, i_item.data[7:6], i_item.data[2:0]};
                        end
                        default: ;
                    endcase
                    n_st.latch = v_latch;
                    n_st.vpage = v_latch[LT_VIDEO] ? VPAGE_SHADOW : VPAGE_NORMAL;
                end
            end
            ACT_FETCH: begin
                if (!r_st.dos) begin
                    if (i_item.pc_high == PC_DOS_ENTRY && r_st.latch[LT_ROM]
                            && !r_st.memcfg[MC_W0_RAM]) begin
                        n_st.dos = 1'b1;
                    end
                end else if (i_item.pc_high >= PC_DOS_EXIT || r_st.memcfg[MC_W0_RAM]) begin
                    n_st.dos = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st.pages    <= {8'd0, 8'd2, 8'd5, 8'd0};
            r_st.memcfg   <= 8'd0;
            r_st.latch    <= 8'd0;
            r_st.vpage    <= VPAGE_NORMAL;
            r_st.power_up <= 1'b1;
            r_st.dos      <= 1'b0;
        end else if (i_en) begin
            r_st <= n_st;
        end
    end

    assign o_next      = n_st;
    assign o_read_data = n_rd;

    a_status_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && i_item.action == ACT_REG_RD && i_item.sel == REG_STATUS
        |=> !r_st.power_up)
        else $error("power-up flag still set after status read");

    a_lock_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && i_item.action == ACT_7FFD && r_st.latch[LT_LOCK]
        |=> $stable(r_st.pages[3]) && $stable(r_st.latch))
        else $error("locked 7FFD write changed paging");

    a_ext1024_nolock: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && i_item.action == ACT_7FFD && !r_st.latch[LT_LOCK]
        && r_st.memcfg[7:6] == EXT_1024K
        |=> !r_st.latch[LT_LOCK])
        else $error("1024K mode write set the lock bit");

    a_dos_ram_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_en && i_item.action == ACT_FETCH && r_st.memcfg[MC_W0_RAM]
        |=> !r_st.dos)
        else $error("disk ROM active while window 0 maps RAM");

endmodule

FILE: hdl/mpp_map.sv
// Window mapping: turns the updated paging state into the result fields.
// Depends on mpp_pkg.
module mpp_map (
    input  mpp_pkg::t_state  i_st,
    input  logic [7:0]       i_read_data,
    output mpp_pkg::t_result o_res
);
    import mpp_pkg::*;

    logic [7:0] p0;
    logic [1:0] rom_low;
    logic       rom;

    always_comb begin
        // disk ROM selects the lower ROM pair, ROM128 picks within the pair
        rom_low = {!i_st.dos, i_st.latch[LT_ROM]};
        if (i_st.memcfg[MC_UNMAPPED]) begin
            p0 = i_st.pages[0];
        end else begin
            p0 = {i_st.pages[0][7:2], rom_low};
        end
        rom = !i_st.memcfg[MC_W0_RAM];

        o_res.read_data  = i_read_data;
        o_res.w0_page    = rom ? (p0 & ROM_PAGE_MSK) : (p0 & PAGE_MASK);
        o_res.w0_rom     = rom;
        o_res.w1_page    = i_st.pages[1] & PAGE_MASK;
        o_res.w2_page    = i_st.pages[2] & PAGE_MASK;
        o_res.w3_page    = i_st.pages[3] & PAGE_MASK;
        o_res.video_page = i_st.vpage;
        o_res.dos_active = i_st.dos;
    end

endmodule

FILE: hdl/memory_paging_port_unit.sv
// Top level of the memory paging port unit: input register, state update,
// window mapping and result register. Depends on mpp_pkg, mpp_state, mpp_map.
//
//  channel | direction | signals                       | one item carries
//  --------+-----------+-------------------------------+--------------------------------
//  s_axis  | in        | tvalid tready tdata tuser     | one bus access or fetch event
//  m_axis  | out       | tvalid tready tdata           | read data and the window mapping
//
// Flow: one item per clock sustained while m_axis_tready stays high; an item
//   passes the input register, then the result register, which loads when free or draining.
// The state update and mapping are combinational between the input and result registers.
// Reset: synchronous, active low; restores the power-up mapping and clears
//   both valid flags.
// Stalls: while a result waits with m_axis_tready low the result register holds, the input
//   register still takes one item, then s_axis_tready drops.
module memory_paging_port_unit (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // [7:0] data, [15:8] pc_high
    input  logic [mpp_pkg::TDATA_IN_W-1:0] s_axis_tdata,
    // [1:0] action, [4:2] register_select
    input  logic [mpp_pkg::TUSER_IN_W-1:0] s_axis_tuser,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // [7:0] read_data, [15:8] window0_page, [16] window0_is_rom,
    // [24:17] window1_page, [32:25] window2_page, [40:33] window3_page,
    // [48:41] video_page, [49] dos_active, [55:50] zero
    output logic [mpp_pkg::TDATA_OUT_W-1:0] m_axis_tdata
);
    import mpp_pkg::*;

    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;

    logic    advance;
    t_state  st_next;
    logic [7:0] read_data;
    t_result res;

    // Move the held item forward when the result register is free or drains.
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    // Capture the item payload; no reset needed.
    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.action  <= t_action'(s_axis_tuser[1:0]);
            r_in.sel     <= s_axis_tuser[4:2];
            r_in.data    <= s_axis_tdata[7:0];
            r_in.pc_high <= s_axis_tdata[15:8];
        end
    end

    // State is committed only when the item moves into the result register.
    mpp_state u_state (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (advance),
        .i_item      (r_in),
        .o_next      (st_next),
        .o_read_data (read_data)
    );

    mpp_map u_map (
        .i_st        (st_next),
        .i_read_data (read_data),
        .o_res       (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {6'd0, r_out.dos_active, r_out.video_page, r_out.w3_page,
                            r_out.w2_page, r_out.w1_page, r_out.w0_rom, r_out.w0_page,
                            r_out.read_data};

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !m_axis_tready |=> r_out_valid && $stable(r_out))
        else $error("result dropped or changed while stalled");

endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for memory_paging_port_unit: drives bus items on s_axis and
// checks every m_axis result against a cycle-free predictor of the paging state.
// Depends on mpp_pkg and the RTL under hdl/; reads no files.
`timescale 1ns / 1ps

module tb_top;
    import mpp_pkg::*;

    // Settle time after the last result.
    localparam int DRAIN_CYCLES = 8;

    // Tracks the paging state item by item and keeps the results still owed by the block.
    class paging_scoreboard;
        logic [7:0] pages [4];
        logic [7:0] memcfg;
        logic [7:0] latch;
        logic [7:0] vpage;
        bit         power_up;
        bit         dos;
        t_result    expected_q [$];
        int         errors;

        function new();
            pages    = '{8'd0, 8'd5, 8'd2, 8'd0};
            memcfg   = 8'h00;
            latch    = 8'h00;
            vpage    = VPAGE_NORMAL;
            power_up = 1'b1;
            dos      = 1'b0;
            errors   = 0;
        endfunction

        // Apply one accepted item to the state and queue the mapping it produces.
        function void note_item(t_item it);
            logic [7:0] v;
            logic [7:0] rd;
            logic [7:0] p0;
            t_result    r;
            rd = RD_NONE;
            case (it.action)
                ACT_REG_WR: begin
                    case (it.sel)
                        REG_MEMCONF: begin
                            memcfg = it.data;
                            latch[LT_ROM] = it.data[MC_ROM128];
                        end
                        REG_PAGE0, REG_PAGE1, REG_PAGE2, REG_PAGE3: begin
                            pages[int'(it.sel) - 1] = it.data;
                        end
                        REG_VPAGE: begin
                            vpage = it.data;
                        end
                        default: ;  // status and dma status take no writes
                    endcase
                end
                ACT_REG_RD: begin
                    case (it.sel)
                        REG_STATUS: begin
                            rd = power_up ? RD_POWER_UP : RD_NONE;
                            power_up = 1'b0;
                        end
                        REG_PAGE2: rd = pages[2];
                        REG_PAGE3: rd = pages[3];
                        REG_DMA:   rd = RD_NONE;
                        default:   rd = RD_OPEN;
                    endcase
                end
                ACT_7FFD: begin
                    if (!latch[LT_LOCK]) begin
                        v = it.data;
                        case (memcfg[7:6])
                            EXT_128K: pages[3] = {5'b0, v[2:0]};
                            EXT_1024K: begin
                                pages[3] = {2'b0, v[5], v[7:6], v[2:0]};
                                v[LT_LOCK] = 1'b0;  // this mode never locks
                            end
                            default: pages[3] = {3'b0, v[7:6], v[2:0]};
                        endcase
                        latch = v;
                        vpage = v[LT_VIDEO] ? VPAGE_SHADOW : VPAGE_NORMAL;
                    end
                end
                ACT_FETCH: begin
                    if (!dos) begin
                        if (it.pc_high == PC_DOS_ENTRY && latch[LT_ROM] && !memcfg[MC_W0_RAM])
                            dos = 1'b1;
                    end else if (it.pc_high >= PC_DOS_EXIT || memcfg[MC_W0_RAM]) begin
                        dos = 1'b0;
                    end
                end
            endcase

            // Mapped window 0 takes its low page bits from the disk-ROM flag and ROM128.
            if (memcfg[MC_UNMAPPED])
                p0 = pages[0];
            else
                p0 = {pages[0][7:2], ~dos, latch[LT_ROM]};

            r.read_data  = rd;
            r.w0_rom     = ~memcfg[MC_W0_RAM];
            r.w0_page    = r.w0_rom ? (p0 & ROM_PAGE_MSK) : (p0 & PAGE_MASK);
            r.w1_page    = pages[1] & PAGE_MASK;
            r.w2_page    = pages[2] & PAGE_MASK;
            r.w3_page    = pages[3] & PAGE_MASK;
            r.video_page = vpage;
            r.dos_active = dos;
            expected_q.push_back(r);
        endfunction

        function void field_check(string name, logic [7:0] e, logic [7:0] a);
            if (a !== e) begin
                errors++;
                $display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, e, a);
            end
        endfunction

        // Compare one accepted result word with the oldest expectation.
        function void check_result(logic [TDATA_OUT_W-1:0] word);
            t_result e;
            if (expected_q.size() == 0) begin
                errors++;
                $display("%0t ns: unexpected result, expected none, actual %h", $time, word);
                return;
            end
            e = expected_q.pop_front();
            field_check("read_data",      e.read_data,         word[7:0]);
            field_check("window0_page",   e.w0_page,           word[15:8]);
            field_check("window0_is_rom", {7'b0, e.w0_rom},    {7'b0, word[16]});
            field_check("window1_page",   e.w1_page,           word[24:17]);
            field_check("window2_page",   e.w2_page,           word[32:25]);
            field_check("window3_page",   e.w3_page,           word[40:33]);
            field_check("video_page",     e.video_page,        word[48:41]);
            field_check("dos_active",     {7'b0, e.dos_active}, {7'b0, word[49]});
            field_check("padding",        8'h00,               {2'b00, word[55:50]});
        endfunction
    endclass

    logic                   i_clk         = 1'b0;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [TDATA_IN_W-1:0]  s_axis_tdata  = '0;
    logic [TUSER_IN_W-1:0]  s_axis_tuser  = '0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [TDATA_OUT_W-1:0] m_axis_tdata;

    // Percent of cycles in which each side holds off.
    int send_idle_pct = 38;
    int recv_idle_pct = 65;

    paging_scoreboard sb = new();

    memory_paging_port_unit u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #5 i_clk = ~i_clk;

    // Stall the result side at random, one decision per cycle.
    always @(posedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Check each result at the edge that takes it.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);
    end

    function automatic t_item make_item(t_action act, logic [2:0] sel, logic [7:0] data,
                                        logic [7:0] pc);
        t_item it;
        it.action  = act;
        it.sel     = sel;
        it.data    = data;
        it.pc_high = pc;
        return it;
    endfunction

    // Draw a random bus item. Keep the lock bit off in locking modes unless asked,
    // since a locked latch stays locked until reset.
    function automatic t_item rand_item(bit allow_lock);
        t_item it;
        int    r;
        it.sel     = 3'($urandom_range(7));
        it.data    = 8'($urandom_range(255));
        it.pc_high = 8'($urandom_range(255));
        r = $urandom_range(99);
        if (r < 20) begin
            it.action = ACT_REG_WR;
        end else if (r < 40) begin
            it.action = ACT_REG_RD;
        end else if (r < 65) begin
            it.action = ACT_7FFD;
            if (!allow_lock && sb.memcfg[7:6] != EXT_1024K)
                it.data[LT_LOCK] = 1'b0;
        end else begin
            it.action = ACT_FETCH;
            r = $urandom_range(9);
            if (r < 4)
                it.pc_high = PC_DOS_ENTRY;
            else if (r < 7)
                it.pc_high = 8'($urandom_range(8'h3F));
            else
                it.pc_high = 8'($urandom_range(255, 8'h40));
        end
        return it;
    endfunction

    // Present one item after a random hold-off, wait for the handshake, then note it.
    // Valid stays high straight into the next item when no hold-off is drawn.
    task automatic send_item(t_item it);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {it.pc_high, it.data};
        s_axis_tuser  <= {it.sel, it.action};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(it);
    endtask

    // Hold the sender until every queued result has come out, then settle.
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (sb.expected_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Mix single random items with well-formed disk-ROM visits: enable ROM128 with
    // window 0 on ROM, fetch at the entry address, do some work, then fetch at an exit or in-ROM address.
    task automatic run_random(int n_items, bit allow_lock);
        int         done;
        int         extra;
        logic [7:0] cfg;
        done = 0;
        while (done < n_items) begin
            if ($urandom_range(3) == 0) begin
                cfg = 8'($urandom_range(255));
                cfg[MC_ROM128] = 1'b1;
                cfg[MC_W0_RAM] = 1'b0;
                extra = $urandom_range(4, 1);
                send_item(make_item(ACT_REG_WR, REG_MEMCONF, cfg, 8'($urandom_range(255))));
                send_item(make_item(ACT_FETCH, 3'($urandom_range(7)), 8'($urandom_range(255)),
                                    PC_DOS_ENTRY));
                repeat (extra) send_item(rand_item(allow_lock));
                send_item(make_item(ACT_FETCH, 3'($urandom_range(7)), 8'($urandom_range(255)),
                                    ($urandom_range(3) == 0) ? 8'($urandom_range(8'h3F))
                                                             : 8'($urandom_range(255, 8'h40))));
                done += extra + 3;
            end else begin
                send_item(rand_item(allow_lock));
                done++;
            end
        end
    endtask

    initial begin
        logic [7:0] cfg;
        logic [7:0] lock_byte;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: power-up status, fixed reads, ignored writes, disk-ROM entry and exit,
        // the 1024K, 128K and auto extension modes, unmapped and RAM window 0, page and video registers.
        send_item(make_item(ACT_REG_RD, REG_STATUS,  8'h00, 8'h00));
        send_item(make_item(ACT_REG_RD, REG_STATUS,  8'h00, 8'h00));
        send_item(make_item(ACT_REG_RD, REG_MEMCONF, 8'h00, 8'h00));
        send_item(make_item(ACT_REG_RD, REG_PAGE2,   8'h00, 8'h00));
        send_item(make_item(ACT_REG_RD, REG_DMA,     8'h00, 8'h00));
        send_item(make_item(ACT_REG_WR, REG_STATUS,  8'hFF, 8'hFF));
        send_item(make_item(ACT_REG_WR, REG_DMA,     8'hFF, 8'hFF));
        send_item(make_item(ACT_REG_WR, REG_MEMCONF, 8'h01, 8'h00));
        send_item(make_item(ACT_FETCH,  REG_MEMCONF, 8'h00, PC_DOS_ENTRY));
        send_item(make_item(ACT_FETCH,  REG_MEMCONF, 8'h00, 8'h3F));
        send_item(make_item(ACT_FETCH,  REG_MEMCONF, 8'h00, PC_DOS_EXIT));
        send_item(make_item(ACT_FETCH,  REG_MEMCONF, 8'h00, PC_DOS_ENTRY));
        // Window 0 on RAM: any fetch leaves the disk-ROM state.
        send_item(make_item(ACT_REG_WR, REG_MEMCONF, 8'h09, 8'h00));
        send_item(make_item(ACT_FETCH,  REG_MEMCONF, 8'h00, 8'h00));
        send_item(make_item(ACT_REG_WR, REG_MEMCONF, {EXT_1024K, 6'h00}, 8'h00));
        send_item(make_item(ACT_7FFD,   REG_MEMCONF, 8'hFF, 8'h00));
        send_item(make_item(ACT_REG_WR, REG_MEMCONF, {EXT_128K, 6'h00}, 8'h00));
        send_item(make_item(ACT_7FFD,   REG_MEMCONF, 8'hD7, 8'h00));
        send_item(make_item(ACT_REG_WR, REG_MEMCONF, {EXT_AUTO, 6'h00}, 8'h00));
        send_item(make_item(ACT_7FFD,   REG_MEMCONF, 8'hC2, 8'h00));
        send_item(make_item(ACT_REG_WR, REG_MEMCONF, 8'h0C, 8'h00));
        send_item(make_item(ACT_REG_WR, REG_PAGE0,   8'hFF, 8'h00));
        send_item(make_item(ACT_REG_WR, REG_MEMCONF, 8'h04, 8'h00));
        send_item(make_item(ACT_REG_WR, REG_PAGE1,   8'hFF, 8'h00));
        send_item(make_item(ACT_REG_WR, REG_VPAGE,   8'hAA, 8'h00));
        send_item(make_item(ACT_REG_RD, REG_PAGE3,   8'h00, 8'h00));

        // Random, in three idling patterns; pause for a full drain between them.
        run_random(440, 1'b0);
        drain();
        send_idle_pct = 65;
        recv_idle_pct = 38;
        run_random(440, 1'b0);
        drain();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        run_random(420, 1'b0);

        // Lock the latch last: it cannot be undone without reset.
        cfg = 8'($urandom_range(255));
        cfg[7:6] = 2'($urandom_range(2));
        lock_byte = 8'($urandom_range(255));
        lock_byte[LT_LOCK] = 1'b1;
        send_item(make_item(ACT_REG_WR, REG_MEMCONF, cfg, 8'h00));
        send_item(make_item(ACT_7FFD, REG_MEMCONF, lock_byte, 8'h00));
        run_random(40, 1'b1);
        drain();

        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // Guard against a hung handshake; far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
